/* sv/wsa_pkg.sv */
`default_nettype none
package wsa_pkg;

   localparam int MAX_CHILDREN_DEF = 16;

   localparam int COORD_W    = 16;
   localparam int CELL_W     = 8;
   localparam int STRETCH_W  = 16;
   localparam int CELLS_W    = 12;
   localparam int INDEX_W    = 6;
   localparam int START_W    = 17;
   localparam int OUT_SIZE_W = 16;
   localparam int SIZE_W     = CELLS_W + CELL_W;
   localparam int PROD_W     = COORD_W + STRETCH_W;
   localparam int DIV_STEPS  = COORD_W;
   localparam int DCNT_W     = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REGION_X      = 3'd0,
      REG_REGION_Y      = 3'd1,
      REG_REGION_WIDTH  = 3'd2,
      REG_REGION_HEIGHT = 3'd3,
      REG_CELL_WIDTH    = 3'd4,
      REG_CELL_HEIGHT   = 3'd5,
      REG_SPLIT_HORIZ   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [STRETCH_W-1:0] stretch_weight;
      logic [CELLS_W-1:0]   min_cells;
      logic [CELLS_W-1:0]   max_cells;
      logic [CELLS_W-1:0]   fixed_cells;
   } slot_type;

   typedef enum logic [4:0] {
      S_LOAD, S_SUM_RD, S_SUM_ACC, S_SUM_END,
      S_SZ_RD, S_SZ_MUL, S_SZ_DIV, S_SZ_FIN,
      S_ADJ_CHK, S_ADJ_RD, S_ADJ_WR, S_FILL_RD, S_FILL_WR,
      S_EMIT_INIT, S_EMIT_RD, S_EMIT_LD, S_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic idle;
      logic load;
      logic sum_acc;
      logic sum_end;
      logic sz_mul;
      logic sz_div;
      logic sz_fin;
      logic adj_chk;
      logic adj_wr;
      logic fill_wr;
      logic emit_init;
      logic emit_ld;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic div_done;
      logic over;
      logic under;
      logic adj_stop;
   } status_type;

endpackage
`default_nettype wire

/* sv/wsa_ram.sv */
`default_nettype none
module wsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/wsa_ctrl.sv */
`default_nettype none
module wsa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last_child,
   input  wire logic                rsp_ready,
   output logic                     req_ready,
   output wsa_pkg::cmd_type         cmd,
   input  wire wsa_pkg::status_type status
);
   wsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsa_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wsa_pkg::S_LOAD: begin
            req_ready = 1'b1;
            cmd.idle  = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_child) state_in = wsa_pkg::S_SUM_RD;
            end
         end
         wsa_pkg::S_SUM_RD: state_in = wsa_pkg::S_SUM_ACC;
         wsa_pkg::S_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in = status.idx_last ? wsa_pkg::S_SUM_END : wsa_pkg::S_SUM_RD;
         end
         wsa_pkg::S_SUM_END: begin
            cmd.sum_end = 1'b1;
            state_in = wsa_pkg::S_SZ_RD;
         end
         wsa_pkg::S_SZ_RD: state_in = wsa_pkg::S_SZ_MUL;
         wsa_pkg::S_SZ_MUL: begin
            cmd.sz_mul = 1'b1;
            state_in = wsa_pkg::S_SZ_DIV;
         end
         wsa_pkg::S_SZ_DIV: begin
            cmd.sz_div = 1'b1;
            if (status.div_done) state_in = wsa_pkg::S_SZ_FIN;
         end
         wsa_pkg::S_SZ_FIN: begin
            cmd.sz_fin = 1'b1;
            state_in = status.idx_last ? wsa_pkg::S_ADJ_CHK : wsa_pkg::S_SZ_RD;
         end
         wsa_pkg::S_ADJ_CHK: begin
            cmd.adj_chk = 1'b1;
            if (status.over) begin
               state_in = wsa_pkg::S_ADJ_RD;
            end else if (status.under) begin
               state_in = wsa_pkg::S_FILL_RD;
            end else begin
               state_in = wsa_pkg::S_EMIT_INIT;
            end
         end
         wsa_pkg::S_ADJ_RD: state_in = wsa_pkg::S_ADJ_WR;
         wsa_pkg::S_ADJ_WR: begin
            cmd.adj_wr = 1'b1;
            state_in = status.adj_stop ? wsa_pkg::S_EMIT_INIT : wsa_pkg::S_ADJ_RD;
         end
         wsa_pkg::S_FILL_RD: state_in = wsa_pkg::S_FILL_WR;
         wsa_pkg::S_FILL_WR: begin
            cmd.fill_wr = 1'b1;
            state_in = wsa_pkg::S_EMIT_INIT;
         end
         wsa_pkg::S_EMIT_INIT: begin
            cmd.emit_init = 1'b1;
            state_in = wsa_pkg::S_EMIT_RD;
         end
         wsa_pkg::S_EMIT_RD: state_in = wsa_pkg::S_EMIT_LD;
         wsa_pkg::S_EMIT_LD: begin
            cmd.emit_ld = 1'b1;
            state_in = wsa_pkg::S_EMIT_OUT;
         end
         wsa_pkg::S_EMIT_OUT: begin
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               state_in = status.idx_last ? wsa_pkg::S_LOAD : wsa_pkg::S_EMIT_RD;
            end
         end
         default: state_in = wsa_pkg::S_LOAD;
      endcase
   end
endmodule
`default_nettype wire

/* sv/wsa_datapath.sv */
`default_nettype none
module wsa_datapath #(
   parameter int MAX_CHILDREN = wsa_pkg::MAX_CHILDREN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire wsa_pkg::cmd_type                 cmd,
   output wsa_pkg::status_type                   status,
   input  wire logic                             csr_write_enable,
   input  wire logic [wsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wsa_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic [wsa_pkg::STRETCH_W-1:0]    req_stretch_weight,
   input  wire logic [wsa_pkg::CELLS_W-1:0]      req_min_cells,
   input  wire logic [wsa_pkg::CELLS_W-1:0]      req_max_cells,
   input  wire logic [wsa_pkg::CELLS_W-1:0]      req_fixed_cells,
   output logic                                  rsp_valid,
   output logic      [wsa_pkg::INDEX_W-1:0]      rsp_child_index,
   output logic      [wsa_pkg::START_W-1:0]      rsp_span_start,
   output logic      [wsa_pkg::OUT_SIZE_W-1:0]   rsp_span_size,
   output logic                                  rsp_last_result
);
   localparam int IDX_W  = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
   localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
   localparam int TW_W   = wsa_pkg::STRETCH_W + $clog2(MAX_CHILDREN);
   localparam int TOT_W  = wsa_pkg::SIZE_W + $clog2(MAX_CHILDREN);
   localparam int SLOT_W = $bits(wsa_pkg::slot_type);
   localparam int SW     = wsa_pkg::SIZE_W;
   localparam int QW     = wsa_pkg::DIV_STEPS;

   // configuration
   logic [wsa_pkg::COORD_W-1:0] region_x_ff, region_y_ff, region_w_ff, region_h_ff;
   logic [wsa_pkg::CELL_W-1:0]  cell_w_ff, cell_h_ff;
   logic                        horiz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_x_ff <= '0;
         region_y_ff <= '0;
         region_w_ff <= '0;
         region_h_ff <= '0;
         cell_w_ff   <= wsa_pkg::CELL_W'(1);
         cell_h_ff   <= wsa_pkg::CELL_W'(1);
         horiz_ff    <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            wsa_pkg::REG_REGION_X:      region_x_ff <= csr_write_data;
            wsa_pkg::REG_REGION_Y:      region_y_ff <= csr_write_data;
            wsa_pkg::REG_REGION_WIDTH:  region_w_ff <= csr_write_data;
            wsa_pkg::REG_REGION_HEIGHT: region_h_ff <= csr_write_data;
            wsa_pkg::REG_CELL_WIDTH:    cell_w_ff   <= csr_write_data[wsa_pkg::CELL_W-1:0];
            wsa_pkg::REG_CELL_HEIGHT:   cell_h_ff   <= csr_write_data[wsa_pkg::CELL_W-1:0];
            wsa_pkg::REG_SPLIT_HORIZ:   horiz_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic [wsa_pkg::COORD_W-1:0] avail;
   logic [wsa_pkg::CELL_W-1:0]  cell_raw, cell_px;
   assign avail    = horiz_ff ? region_w_ff : region_h_ff;
   assign cell_raw = horiz_ff ? cell_w_ff : cell_h_ff;
   assign cell_px  = (cell_raw == '0) ? wsa_pkg::CELL_W'(1) : cell_raw;

   // working registers
   logic [CNT_W-1:0]           cnt_ff, cnt_in, idx_ff, idx_in, flex_ff, flex_in;
   logic                       found_ff, found_in;
   logic [TOT_W-1:0]           tf_ff, tf_in, tot_ff, tot_in, diff_ff, diff_in;
   logic [TW_W-1:0]            tw_ff, tw_in, r_ff, r_in;
   logic [wsa_pkg::COORD_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]              q_ff, q_in;
   logic [wsa_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [SW-1:0]              lo_ff, lo_in, hi_ff, hi_in;
   logic [wsa_pkg::START_W-1:0] cursor_ff, cursor_in;
   logic                       vld_ff, vld_in;
   logic [wsa_pkg::INDEX_W-1:0] oidx_ff, oidx_in;
   logic [wsa_pkg::START_W-1:0] ostart_ff, ostart_in;
   logic [wsa_pkg::OUT_SIZE_W-1:0] osize_ff, osize_in;
   logic                       olast_ff, olast_in;

   // stores
   logic [SLOT_W-1:0]  slot_rd;
   wsa_pkg::slot_type  slot, slot_wr;
   logic               slot_we;
   logic [SW-1:0]      size_rd, size_wr;
   logic               size_we;

   assign slot    = wsa_pkg::slot_type'(slot_rd);
   assign slot_wr = '{stretch_weight: req_stretch_weight, min_cells: req_min_cells,
                      max_cells: req_max_cells, fixed_cells: req_fixed_cells};
   assign slot_we = cmd.load && (cnt_ff < CNT_W'(MAX_CHILDREN));

   wsa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_CHILDREN)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (slot_wr),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (slot_rd)
   );

   wsa_ram #(.WIDTH(SW), .DEPTH(MAX_CHILDREN)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (size_wr),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (size_rd)
   );

   // shared cell multiplier
   logic [wsa_pkg::CELLS_W-1:0] mul_cells;
   logic [SW-1:0]               mul_px;
   logic                        is_fixed;
   assign is_fixed = slot.fixed_cells != '0;
   always_comb begin
      if (cmd.sz_div) begin
         mul_cells = slot.max_cells;
      end else if (cmd.sz_mul) begin
         mul_cells = is_fixed ? slot.fixed_cells : slot.min_cells;
      end else begin
         mul_cells = slot.fixed_cells;
      end
   end
   assign mul_px = SW'(mul_cells * cell_px);

   // share product and divider step
   logic [wsa_pkg::PROD_W-1:0] prod;
   logic [TW_W:0]              dv_t;
   logic                       dv_ge;
   assign prod  = rem_ff * slot.stretch_weight;
   assign dv_t  = {r_ff, q_ff[QW-1]};
   assign dv_ge = dv_t >= {1'b0, tw_ff};

   // size selection
   logic [SW-1:0] want, capped;
   always_comb begin
      capped = SW'(q_ff);
      if (slot.max_cells != '0 && capped > hi_ff) capped = hi_ff;
      if (capped < lo_ff) capped = lo_ff;
      if (is_fixed) begin
         want = lo_ff;
      end else if (tw_ff != '0 && rem_ff != '0) begin
         want = capped;
      end else begin
         want = lo_ff;
      end
   end

   logic [TOT_W-1:0] avail_x, size_x, take, diff_left;
   assign avail_x   = TOT_W'(avail);
   assign size_x    = TOT_W'(size_rd);
   assign take      = (size_x < diff_ff) ? size_x : diff_ff;
   assign diff_left = diff_ff - take;

   logic idx_last;
   assign idx_last = (idx_ff + CNT_W'(1)) == cnt_ff;

   assign status.idx_last = idx_last;
   assign status.div_done = dcnt_ff == wsa_pkg::DCNT_W'(wsa_pkg::DIV_STEPS - 1);
   assign status.over     = tot_ff > avail_x;
   assign status.under    = (tot_ff < avail_x) && found_ff;
   assign status.adj_stop = (diff_left == '0) || (idx_ff == '0);

   always_comb begin
      cnt_in = cnt_ff;   idx_in = idx_ff;   flex_in = flex_ff; found_in = found_ff;
      tf_in = tf_ff;     tot_in = tot_ff;   diff_in = diff_ff; tw_in = tw_ff;
      r_in = r_ff;       rem_in = rem_ff;   q_in = q_ff;       dcnt_in = dcnt_ff;
      lo_in = lo_ff;     hi_in = hi_ff;     cursor_in = cursor_ff;
      vld_in = vld_ff;   oidx_in = oidx_ff; ostart_in = ostart_ff;
      osize_in = osize_ff; olast_in = olast_ff;
      size_we = 1'b0;
      size_wr = want;

      if (cmd.idle) begin
         idx_in = '0;
         tf_in  = '0;
         tw_in  = '0;
      end
      if (slot_we) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.sum_acc) begin
         if (is_fixed) begin
            tf_in = tf_ff + TOT_W'(mul_px);
         end else begin
            tw_in = tw_ff + TW_W'(slot.stretch_weight);
         end
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.sum_end) begin
         rem_in   = (avail_x > tf_ff) ? wsa_pkg::COORD_W'(avail_x - tf_ff) : '0;
         idx_in   = '0;
         tot_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.sz_mul) begin
         r_in    = TW_W'(prod[wsa_pkg::PROD_W-1:QW]);
         q_in    = prod[QW-1:0];
         lo_in   = mul_px;
         dcnt_in = '0;
      end
      if (cmd.sz_div) begin
         r_in    = dv_ge ? TW_W'(dv_t - {1'b0, tw_ff}) : TW_W'(dv_t);
         q_in    = {q_ff[QW-2:0], dv_ge};
         dcnt_in = dcnt_ff + wsa_pkg::DCNT_W'(1);
         if (dcnt_ff == '0) hi_in = mul_px;
      end
      if (cmd.sz_fin) begin
         size_we = 1'b1;
         size_wr = want;
         tot_in  = tot_ff + TOT_W'(want);
         if (!is_fixed && slot.stretch_weight != '0) begin
            flex_in  = idx_ff;
            found_in = 1'b1;
         end
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.adj_chk) begin
         if (tot_ff > avail_x) begin
            diff_in = tot_ff - avail_x;
            idx_in  = cnt_ff - CNT_W'(1);
         end else begin
            diff_in = avail_x - tot_ff;
            idx_in  = flex_ff;
         end
      end
      if (cmd.adj_wr) begin
         size_we = 1'b1;
         size_wr = SW'(size_x - take);
         diff_in = diff_left;
         idx_in  = idx_ff - CNT_W'(1);
      end
      if (cmd.fill_wr) begin
         size_we = 1'b1;
         size_wr = SW'(size_x + diff_ff);
      end
      if (cmd.emit_init) begin
         idx_in    = '0;
         cursor_in = wsa_pkg::START_W'(horiz_ff ? region_x_ff : region_y_ff);
      end
      if (cmd.emit_ld) begin
         vld_in    = 1'b1;
         oidx_in   = wsa_pkg::INDEX_W'(idx_ff);
         ostart_in = cursor_ff;
         osize_in  = size_rd[wsa_pkg::OUT_SIZE_W-1:0];
         olast_in  = idx_last;
         cursor_in = cursor_ff + size_rd[wsa_pkg::START_W-1:0];
      end
      if (cmd.emit_next) begin
         vld_in = 1'b0;
         idx_in = idx_ff + CNT_W'(1);
         if (idx_last) cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      flex_ff   <= flex_in;
      found_ff  <= found_in;
      tf_ff     <= tf_in;
      tot_ff    <= tot_in;
      diff_ff   <= diff_in;
      tw_ff     <= tw_in;
      r_ff      <= r_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      dcnt_ff   <= dcnt_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      cursor_ff <= cursor_in;
      oidx_ff   <= oidx_in;
      ostart_ff <= ostart_in;
      osize_ff  <= osize_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_child_index = oidx_ff;
   assign rsp_span_start  = ostart_ff;
   assign rsp_span_size   = osize_ff;
   assign rsp_last_result = olast_ff;
endmodule
`default_nettype wire

/* sv/weighted_span_allocator.sv */
// weighted span allocator: splits one axis of a region among loaded children
// req channel: one child record per beat; a beat with last_child set closes
// the batch and starts allocation. records beyond MAX_CHILDREN are dropped,
// but their last_child mark still starts allocation.
// csr port: plain write, one register per index; the user writes only while
// the block is idle, and the block itself does not enforce it.
// after the last beat: a summing pass, a sizing pass (one 16-step restoring
// divider shared by all children), a correction pass, then the rsp beats.
// rsp channel: one beat per child in load order, last_result on the final
// one. a stalled receiver holds the beat in the output register; req_ready
// stays low until the last rsp beat is taken.
// reset: config registers go to region 0, cell size 1, horizontal split;
// the batch is emptied. child stores hold no reset value.
`default_nettype none
module weighted_span_allocator #(
   parameter int MAX_CHILDREN = wsa_pkg::MAX_CHILDREN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [wsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wsa_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [wsa_pkg::STRETCH_W-1:0]    req_stretch_weight,
   input  wire logic [wsa_pkg::CELLS_W-1:0]      req_min_cells,
   input  wire logic [wsa_pkg::CELLS_W-1:0]      req_max_cells,
   input  wire logic [wsa_pkg::CELLS_W-1:0]      req_fixed_cells,
   input  wire logic                             req_last_child,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [wsa_pkg::INDEX_W-1:0]      rsp_child_index,
   output logic      [wsa_pkg::START_W-1:0]      rsp_span_start,
   output logic      [wsa_pkg::OUT_SIZE_W-1:0]   rsp_span_size,
   output logic                                  rsp_last_result
);
   wsa_pkg::cmd_type    cmd;
   wsa_pkg::status_type status;

   wsa_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_child (req_last_child),
      .rsp_ready      (rsp_ready),
      .req_ready      (req_ready),
      .cmd            (cmd),
      .status         (status)
   );

   wsa_datapath #(.MAX_CHILDREN(MAX_CHILDREN)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_stretch_weight (req_stretch_weight),
      .req_min_cells      (req_min_cells),
      .req_max_cells      (req_max_cells),
      .req_fixed_cells    (req_fixed_cells),
      .rsp_valid          (rsp_valid),
      .rsp_child_index    (rsp_child_index),
      .rsp_span_start     (rsp_span_start),
      .rsp_span_size      (rsp_span_size),
      .rsp_last_result    (rsp_last_result)
   );

   // no new record while a result beat is pending
   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while rsp beat pending");

   // a taken result beat is not shown again
   a_rsp_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("rsp beat repeated");

   // last record closes the input side
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_child) |=> !req_ready)
      else $error("req_ready high after last record");
endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
import wsa_pkg::*;

typedef struct {
   bit [INDEX_W-1:0]    index;
   bit [START_W-1:0]    start;
   bit [OUT_SIZE_W-1:0] size;
   bit                  last;
} span_beat_type;

class span_scoreboard;
   bit [15:0] region_x, region_y, region_width, region_height;
   bit [7:0]  cell_width, cell_height;
   bit        split_horiz;
   slot_type  batch[$];
   span_beat_type spans[$];
   int errors;

   function new();
      region_x = 0; region_y = 0; region_width = 0; region_height = 0;
      cell_width = 1; cell_height = 1; split_horiz = 1;
      errors = 0;
   endfunction

   function void set_reg(reg_index_type r, bit [15:0] v);
      case (r)
         REG_REGION_X:      region_x = v;
         REG_REGION_Y:      region_y = v;
         REG_REGION_WIDTH:  region_width = v;
         REG_REGION_HEIGHT: region_height = v;
         REG_CELL_WIDTH:    cell_width = v[7:0];
         REG_CELL_HEIGHT:   cell_height = v[7:0];
         REG_SPLIT_HORIZ:   split_horiz = v[0];
         default: ;
      endcase
   endfunction

   function int pending();
      return spans.size();
   endfunction

   function void allocate_spans();
      longint avail, cell_px, remaining, total, tfixed, tweight, want, minpx, excess, take;
      longint cursor;
      bit [31:0] sizes[MAX_CHILDREN_DEF];
      span_beat_type b;
      int n;
      n = batch.size();
      avail = split_horiz ? longint'(region_width) : longint'(region_height);
      cell_px = split_horiz ? longint'(cell_width) : longint'(cell_height);
      if (cell_px == 0) cell_px = 1;
      tfixed = 0; tweight = 0; total = 0;
      for (int i = 0; i < n; i++) begin
         if (batch[i].fixed_cells != 0) tfixed += batch[i].fixed_cells * cell_px;
         else tweight += batch[i].stretch_weight;
      end
      remaining = (avail > tfixed) ? avail - tfixed : 0;
      for (int i = 0; i < n; i++) begin
         minpx = batch[i].min_cells * cell_px;
         if (batch[i].fixed_cells != 0) begin
            want = batch[i].fixed_cells * cell_px;
         end else if (tweight > 0 && remaining > 0) begin
            want = (remaining * batch[i].stretch_weight) / tweight;
            if (batch[i].max_cells != 0 && want > batch[i].max_cells * cell_px)
               want = batch[i].max_cells * cell_px;
            if (want < minpx) want = minpx;
         end else begin
            want = minpx;
         end
         sizes[i] = want[31:0];
         total += want;
      end
      if (total > avail) begin
         excess = total - avail;
         for (int i = n - 1; i >= 0 && excess > 0; i--) begin
            take = (sizes[i] < excess) ? longint'(sizes[i]) : excess;
            sizes[i] -= take[31:0];
            excess -= take;
         end
      end else if (total < avail) begin
         for (int i = n - 1; i >= 0; i--) begin
            if (batch[i].fixed_cells == 0 && batch[i].stretch_weight > 0) begin
               sizes[i] += 32'(avail - total);
               break;
            end
         end
      end
      cursor = split_horiz ? longint'(region_x) : longint'(region_y);
      for (int i = 0; i < n; i++) begin
         b.index = i[INDEX_W-1:0];
         b.start = cursor[START_W-1:0];
         b.size  = sizes[i][OUT_SIZE_W-1:0];
         b.last  = (i == n - 1);
         spans = {spans, b};
         cursor += sizes[i];
      end
      batch.delete();
   endfunction

   function void note_child(slot_type s, bit last);
      if (batch.size() < MAX_CHILDREN_DEF) batch = {batch, s};
      if (last) allocate_spans();
   endfunction

   function void check_beat(span_beat_type got);
      span_beat_type exp_b;
      if (spans.size() == 0) begin
         $error("unexpected rsp beat index %0d", got.index);
         errors++;
         return;
      end
      exp_b = spans.pop_front();
      if (got.index != exp_b.index) begin
         $error("child_index expected %0d actual %0d", exp_b.index, got.index);
         errors++;
      end
      if (got.start != exp_b.start) begin
         $error("span_start expected %0d actual %0d", exp_b.start, got.start);
         errors++;
      end
      if (got.size != exp_b.size) begin
         $error("span_size expected %0d actual %0d", exp_b.size, got.size);
         errors++;
      end
      if (got.last != exp_b.last) begin
         $error("last_result expected %0d actual %0d", exp_b.last, got.last);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [STRETCH_W-1:0]  req_stretch_weight;
   logic [CELLS_W-1:0]    req_min_cells;
   logic [CELLS_W-1:0]    req_max_cells;
   logic [CELLS_W-1:0]    req_fixed_cells;
   logic                  req_last_child;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [INDEX_W-1:0]    rsp_child_index;
   logic [START_W-1:0]    rsp_span_start;
   logic [OUT_SIZE_W-1:0] rsp_span_size;
   logic                  rsp_last_result;
   logic                  quiet;
   int                    items;

   span_scoreboard sb = new();

   weighted_span_allocator u_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      span_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.index = rsp_child_index;
         got.start = rsp_span_start;
         got.size  = rsp_span_size;
         got.last  = rsp_last_result;
         sb.check_beat(got);
      end
   end

   task automatic write_reg(reg_index_type r, bit [15:0] v);
      csr_write_enable <= 1;
      csr_index <= r;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
      sb.set_reg(r, v);
   endtask

   task automatic set_region(bit [15:0] x, bit [15:0] y, bit [15:0] w, bit [15:0] h,
                             bit [7:0] cw, bit [7:0] ch, bit horiz);
      write_reg(REG_REGION_X, x);
      write_reg(REG_REGION_Y, y);
      write_reg(REG_REGION_WIDTH, w);
      write_reg(REG_REGION_HEIGHT, h);
      write_reg(REG_CELL_WIDTH, 16'(cw));
      write_reg(REG_CELL_HEIGHT, 16'(ch));
      write_reg(REG_SPLIT_HORIZ, 16'(horiz));
   endtask

   task automatic send_child(bit [15:0] sw, bit [11:0] mn, bit [11:0] mx, bit [11:0] fx,
                             bit last);
      slot_type s;
      while (!quiet && $urandom_range(99) < 19) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_stretch_weight <= sw;
      req_min_cells <= mn;
      req_max_cells <= mx;
      req_fixed_cells <= fx;
      req_last_child <= last;
      do @(posedge clock); while (!req_ready);
      s.stretch_weight = sw; s.min_cells = mn; s.max_cells = mx; s.fixed_cells = fx;
      sb.note_child(s, last);
      items++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_batch();
      int n;
      bit [15:0] sw;
      bit [11:0] mn, mx, fx;
      n = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) begin
            sw = 16'($urandom); mn = 12'($urandom); mx = 12'($urandom); fx = 12'($urandom);
         end else begin
            sw = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(1, 50));
            mn = 12'($urandom_range(0, 4));
            mx = ($urandom_range(2) == 0) ? 12'($urandom_range(1, 30)) : 12'd0;
            fx = ($urandom_range(3) == 0) ? 12'($urandom_range(1, 20)) : 12'd0;
         end
         send_child(sw, mn, mx, fx, i == n - 1);
      end
   endtask

   initial begin
      reset = 1;
      quiet = 0;
      items = 0;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 0;
      req_stretch_weight = '0;
      req_min_cells = '0;
      req_max_cells = '0;
      req_fixed_cells = '0;
      req_last_child = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset region is empty: flexible children fall back to minimum
      send_child(16'd5, 12'd2, 12'd0, 12'd0, 1);
      drain();

      set_region(16'd10, 16'd0, 16'd100, 16'd0, 8'd0, 8'd1, 1'b1);
      send_child(16'd1, 12'd0, 12'd0, 12'd0, 0);
      send_child(16'd0, 12'd0, 12'd0, 12'd20, 0);
      send_child(16'd3, 12'd2, 12'd10, 12'd0, 0);
      send_child(16'd0, 12'd5, 12'd0, 12'd0, 1);
      drain();
      send_child(16'hFFFF, 12'hFFF, 12'hFFF, 12'd0, 1);
      drain();
      // no stretchy child, leftover unassigned
      send_child(16'd0, 12'd1, 12'd0, 12'd0, 0);
      send_child(16'd0, 12'd0, 12'd0, 12'd3, 1);
      drain();
      // records past the limit are dropped
      for (int i = 0; i < 18; i++) send_child(16'(i), 12'd0, 12'd0, 12'(i % 3), i == 17);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_region(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 8'hFF, 8'd0, 1'b1);
            1: set_region(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd1, 8'hFF, 1'b0);
            2: set_region(16'($urandom), 16'($urandom), 16'($urandom_range(0, 400)),
                          16'($urandom_range(0, 400)), 8'($urandom_range(0, 4)),
                          8'($urandom_range(0, 4)), 1'b0);
            default: set_region(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 8'($urandom), 8'($urandom),
                                1'($urandom));
         endcase
         while (items < 30 + (ph + 1) * 23) begin
            quiet <= (ph == 3);
            random_batch();
            drain();
         end
      end
      quiet <= 0;
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
